>>> design/gac_pkg.sv
// Shared types and constants for the gamepad axis conditioner.
package gac_pkg;

  localparam int AXIS_BITS = 16;
  localparam int FRAC_BITS = AXIS_BITS - 1;

  localparam int STICK_DZ_RESET   = 4915;
  localparam int TRIGGER_DZ_RESET = 3277;

  localparam int CFG_INDEX_BITS = 2;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_STICK_DZ   = 2'd0,
    REG_TRIGGER_DZ = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [AXIS_BITS-1:0] raw_left_x;
    logic signed [AXIS_BITS-1:0] raw_left_y;
    logic signed [AXIS_BITS-1:0] raw_right_x;
    logic signed [AXIS_BITS-1:0] raw_right_y;
    logic signed [AXIS_BITS-1:0] raw_left_trigger;
    logic signed [AXIS_BITS-1:0] raw_right_trigger;
  } sample_t;

  typedef struct packed {
    logic signed [AXIS_BITS-1:0] out_left_x;
    logic signed [AXIS_BITS-1:0] out_left_y;
    logic signed [AXIS_BITS-1:0] out_right_x;
    logic signed [AXIS_BITS-1:0] out_right_y;
    logic [FRAC_BITS-1:0]        out_left_trigger;
    logic [FRAC_BITS-1:0]        out_right_trigger;
    logic                        left_stick_active;
    logic                        right_stick_active;
    logic                        left_trigger_active;
    logic                        right_trigger_active;
  } result_t;

endpackage

>>> design/gac_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module gac_sqrt import gac_pkg::*; #(
  parameter int IN_BITS   = 2 * AXIS_BITS,
  parameter int SIDE_BITS = 1
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [IN_BITS-1:0]     radicand,
  input  logic [SIDE_BITS-1:0]   side_in,
  output logic [IN_BITS/2-1:0]   root,
  output logic [SIDE_BITS-1:0]   side_out
);

  localparam int RW = IN_BITS / 2;

  logic [IN_BITS-1:0]   rad_q  [RW];
  logic [RW:0]          rem_q  [RW];
  logic [RW-1:0]        root_q [RW];
  logic [SIDE_BITS-1:0] side_q [RW];

  for (genvar k = 0; k < RW; k++) begin : g_step
    logic [IN_BITS-1:0]   rad_prev;
    logic [RW:0]          rem_prev;
    logic [RW-1:0]        root_prev;
    logic [SIDE_BITS-1:0] side_prev;
    logic [RW+2:0]        rem_sh;
    logic [RW+2:0]        trial;
    logic [RW:0]          rem_n;
    logic [RW-1:0]        root_n;

    if (k == 0) begin : g_first
      assign rad_prev  = radicand;
      assign rem_prev  = '0;
      assign root_prev = '0;
      assign side_prev = side_in;
    end else begin : g_rest
      assign rad_prev  = rad_q[k-1];
      assign rem_prev  = rem_q[k-1];
      assign root_prev = root_q[k-1];
      assign side_prev = side_q[k-1];
    end

    always_comb begin
      rem_sh = {rem_prev, rad_prev[IN_BITS-1-2*k -: 2]};
      trial  = {1'b0, root_prev, 2'b01};
      if (rem_sh >= trial) begin
        rem_n  = (RW+1)'(rem_sh - trial);
        root_n = {root_prev[RW-2:0], 1'b1};
      end else begin
        rem_n  = rem_sh[RW:0];
        root_n = {root_prev[RW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_q[k]  <= rad_prev;
        rem_q[k]  <= rem_n;
        root_q[k] <= root_n;
        side_q[k] <= side_prev;
      end
    end
  end

  assign root     = root_q[RW-1];
  assign side_out = side_q[RW-1];

endmodule

>>> design/gac_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module gac_div import gac_pkg::*; #(
  parameter int DEN_BITS  = AXIS_BITS,
  parameter int QUO_BITS  = AXIS_BITS,
  parameter int SIDE_BITS = 1
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [DEN_BITS-1:0]  rem_init,
  input  logic [QUO_BITS-1:0]  low,
  input  logic [DEN_BITS-1:0]  den,
  input  logic [SIDE_BITS-1:0] side_in,
  output logic [QUO_BITS-1:0]  quo,
  output logic [SIDE_BITS-1:0] side_out
);

  // The upper dividend bits (rem_init) must already be below the divisor.
  logic [DEN_BITS-1:0]  rem_q  [QUO_BITS];
  logic [QUO_BITS-1:0]  low_q  [QUO_BITS];
  logic [QUO_BITS-1:0]  quo_q  [QUO_BITS];
  logic [DEN_BITS-1:0]  den_q  [QUO_BITS];
  logic [SIDE_BITS-1:0] side_q [QUO_BITS];

  for (genvar k = 0; k < QUO_BITS; k++) begin : g_step
    logic [DEN_BITS-1:0]  rem_prev;
    logic [QUO_BITS-1:0]  low_prev;
    logic [QUO_BITS-1:0]  quo_prev;
    logic [DEN_BITS-1:0]  den_prev;
    logic [SIDE_BITS-1:0] side_prev;
    logic [DEN_BITS:0]    rem_sh;
    logic [DEN_BITS-1:0]  rem_n;
    logic [QUO_BITS-1:0]  quo_n;

    if (k == 0) begin : g_first
      assign rem_prev  = rem_init;
      assign low_prev  = low;
      assign quo_prev  = '0;
      assign den_prev  = den;
      assign side_prev = side_in;
    end else begin : g_rest
      assign rem_prev  = rem_q[k-1];
      assign low_prev  = low_q[k-1];
      assign quo_prev  = quo_q[k-1];
      assign den_prev  = den_q[k-1];
      assign side_prev = side_q[k-1];
    end

    always_comb begin
      rem_sh = {rem_prev, low_prev[QUO_BITS-1-k]};
      if (rem_sh >= {1'b0, den_prev}) begin
        rem_n = DEN_BITS'(rem_sh - {1'b0, den_prev});
        quo_n = {quo_prev[QUO_BITS-2:0], 1'b1};
      end else begin
        rem_n = rem_sh[DEN_BITS-1:0];
        quo_n = {quo_prev[QUO_BITS-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= rem_n;
        low_q[k]  <= low_prev;
        quo_q[k]  <= quo_n;
        den_q[k]  <= den_prev;
        side_q[k] <= side_prev;
      end
    end
  end

  assign quo      = quo_q[QUO_BITS-1];
  assign side_out = side_q[QUO_BITS-1];

endmodule

>>> design/gac_stick.sv
// Radial deadzone and rescale pipeline for one stick pair.
module gac_stick import gac_pkg::*; #(
  parameter int AXIS_BITS = gac_pkg::AXIS_BITS,
  parameter int SIDE_BITS = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic signed [AXIS_BITS-1:0] x,
  input  logic signed [AXIS_BITS-1:0] y,
  input  logic [SIDE_BITS-1:0]        side_in,
  input  logic [AXIS_BITS-2:0]        dz,
  input  logic [2*AXIS_BITS-3:0]      dz_sq,
  input  logic [AXIS_BITS-1:0]        den,
  output logic                        out_valid,
  output logic signed [AXIS_BITS-1:0] out_x,
  output logic signed [AXIS_BITS-1:0] out_y,
  output logic                        active,
  output logic [SIDE_BITS-1:0]        side_out
);

  localparam int W   = AXIS_BITS;
  localparam int F   = AXIS_BITS - 1;
  localparam int LAT = 3 * F + 9;
  localparam int SB1 = 3 + 2 * W + SIDE_BITS;
  localparam int SB2 = 5 + 3 * W + SIDE_BITS;
  localparam int SBX = 3 + SIDE_BITS;

  logic [LAT-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  assign out_valid = vld[LAT-1];

  // Magnitudes and signs.
  logic [W-1:0]         ax1, ay1;
  logic                 sx1, sy1;
  logic [SIDE_BITS-1:0] side1;

  always_ff @(posedge clk) begin
    if (en) begin
      ax1   <= x[F] ? (~x + 1'b1) : x;
      ay1   <= y[F] ? (~y + 1'b1) : y;
      sx1   <= x[F];
      sy1   <= y[F];
      side1 <= side_in;
    end
  end

  // Squares.
  logic [2*W-1:0]       mulx, muly;
  logic [2*F:0]         sqx2, sqy2;
  logic [W-1:0]         ax2, ay2;
  logic                 sx2, sy2;
  logic [SIDE_BITS-1:0] side2;

  assign mulx = ax1 * ax1;
  assign muly = ay1 * ay1;

  always_ff @(posedge clk) begin
    if (en) begin
      sqx2  <= mulx[2*F:0];
      sqy2  <= muly[2*F:0];
      ax2   <= ax1;
      ay2   <= ay1;
      sx2   <= sx1;
      sy2   <= sy1;
      side2 <= side1;
    end
  end

  // Squared length and deadzone test.
  logic [2*W-1:0]       sum2;
  logic [2*W-1:0]       sq3;
  logic                 act3;
  logic [W-1:0]         ax3, ay3;
  logic                 sx3, sy3;
  logic [SIDE_BITS-1:0] side3;

  assign sum2 = {1'b0, sqx2} + {1'b0, sqy2};

  always_ff @(posedge clk) begin
    if (en) begin
      sq3   <= sum2;
      act3  <= sum2 >= {2'b00, dz_sq};
      ax3   <= ax2;
      ay3   <= ay2;
      sx3   <= sx2;
      sy3   <= sy2;
      side3 <= side2;
    end
  end

  logic [W-1:0]         len_s;
  logic [SB1-1:0]       sq_side;
  logic                 act_s, sx_s, sy_s;
  logic [W-1:0]         ax_s, ay_s;
  logic [SIDE_BITS-1:0] side_s;

  gac_sqrt #(
    .IN_BITS  (2 * W),
    .SIDE_BITS(SB1)
  ) u_sqrt (
    .clk     (clk),
    .en      (en),
    .radicand(sq3),
    .side_in ({act3, sx3, sy3, ax3, ay3, side3}),
    .root    (len_s),
    .side_out(sq_side)
  );

  assign {act_s, sx_s, sy_s, ax_s, ay_s, side_s} = sq_side;

  // Distance past the deadzone; at or past the full span the rescale saturates to one.
  logic [W-1:0]         rdiff;
  logic [W-1:0]         rem4;
  logic [W-1:0]         len4;
  logic                 sat4, lenz4, act4, sx4, sy4;
  logic [W-1:0]         ax4, ay4;
  logic [SIDE_BITS-1:0] side4;

  assign rdiff = len_s - {1'b0, dz};

  always_ff @(posedge clk) begin
    if (en) begin
      sat4  <= rdiff >= den;
      rem4  <= (rdiff >= den) ? '0 : rdiff;
      len4  <= len_s;
      lenz4 <= (len_s == '0);
      act4  <= act_s;
      sx4   <= sx_s;
      sy4   <= sy_s;
      ax4   <= ax_s;
      ay4   <= ay_s;
      side4 <= side_s;
    end
  end

  logic [F-1:0]         r_quo;
  logic [SB2-1:0]       r_side;
  logic                 sat_r, lenz_r, act_r, sx_r, sy_r;
  logic [W-1:0]         ax_r, ay_r, len_r;
  logic [SIDE_BITS-1:0] side_r;

  gac_div #(
    .DEN_BITS (W),
    .QUO_BITS (F),
    .SIDE_BITS(SB2)
  ) u_div_r (
    .clk     (clk),
    .en      (en),
    .rem_init(rem4),
    .low     ({F{1'b0}}),
    .den     (den),
    .side_in ({sat4, lenz4, act4, sx4, sy4, ax4, ay4, len4, side4}),
    .quo     (r_quo),
    .side_out(r_side)
  );

  assign {sat_r, lenz_r, act_r, sx_r, sy_r, ax_r, ay_r, len_r, side_r} = r_side;

  // Scale the magnitudes by the rescaled length.
  logic [W-1:0]         r_val;
  logic [2*W-1:0]       mpx, mpy;
  logic [2*F:0]         px5, py5;
  logic [W-1:0]         len5;
  logic                 lenz5, act5, sx5, sy5;
  logic [SIDE_BITS-1:0] side5;

  assign r_val = sat_r ? {1'b1, {F{1'b0}}} : {1'b0, r_quo};
  assign mpx   = ax_r * r_val;
  assign mpy   = ay_r * r_val;

  always_ff @(posedge clk) begin
    if (en) begin
      px5   <= mpx[2*F:0];
      py5   <= mpy[2*F:0];
      len5  <= len_r;
      lenz5 <= lenz_r;
      act5  <= act_r;
      sx5   <= sx_r;
      sy5   <= sy_r;
      side5 <= side_r;
    end
  end

  // Add half the divisor so the final quotient rounds to nearest.
  logic [2*F:0]         dx6, dy6;
  logic [W-1:0]         len6;
  logic                 lenz6, act6, sx6, sy6;
  logic [SIDE_BITS-1:0] side6;

  always_ff @(posedge clk) begin
    if (en) begin
      dx6   <= px5 + {{F{1'b0}}, 1'b0, len5[W-1:1]};
      dy6   <= py5 + {{F{1'b0}}, 1'b0, len5[W-1:1]};
      len6  <= len5;
      lenz6 <= lenz5;
      act6  <= act5;
      sx6   <= sx5;
      sy6   <= sy5;
      side6 <= side5;
    end
  end

  logic [W-1:0]         qx, qy;
  logic [SBX-1:0]       qx_side;
  logic                 qy_side;
  logic                 lenz_q, act_q, sx_q;
  logic [SIDE_BITS-1:0] side_q;

  gac_div #(
    .DEN_BITS (W),
    .QUO_BITS (W),
    .SIDE_BITS(SBX)
  ) u_div_x (
    .clk     (clk),
    .en      (en),
    .rem_init({1'b0, dx6[2*F:W]}),
    .low     (dx6[W-1:0]),
    .den     (len6),
    .side_in ({lenz6, act6, sx6, side6}),
    .quo     (qx),
    .side_out(qx_side)
  );

  gac_div #(
    .DEN_BITS (W),
    .QUO_BITS (W),
    .SIDE_BITS(1)
  ) u_div_y (
    .clk     (clk),
    .en      (en),
    .rem_init({1'b0, dy6[2*F:W]}),
    .low     (dy6[W-1:0]),
    .den     (len6),
    .side_in (sy6),
    .quo     (qy),
    .side_out(qy_side)
  );

  assign {lenz_q, act_q, sx_q, side_q} = qx_side;

  function automatic logic [W-1:0] apply_sign(input logic neg, input logic [W-1:0] q);
    logic [W-1:0] res;
    if (neg) begin
      res = (q > {1'b1, {F{1'b0}}}) ? {1'b1, {F{1'b0}}} : (~q + 1'b1);
    end else begin
      res = q[F] ? {1'b0, {F{1'b1}}} : q;
    end
    return res;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      if (lenz_q || !act_q) begin
        out_x <= '0;
        out_y <= '0;
      end else begin
        out_x <= apply_sign(sx_q, qx);
        out_y <= apply_sign(qy_side, qy);
      end
      active   <= act_q;
      side_out <= side_q;
    end
  end

endmodule

>>> design/gamepad_axis_conditioner.sv
// Top level of the gamepad axis conditioner: configuration, triggers and stick pipelines.
//
// One sample is taken every clock cycle while no stalled result holds the pipeline. Each
// stick path runs a square-root pipeline, a rescale divider and two axis dividers, which
// resolve one bit per register stage.
// A stalled result holds the whole pipeline; configuration writes are always taken and
// must only be issued while no sample is in flight.
module gamepad_axis_conditioner import gac_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      sample_valid,
  output logic                      sample_stall,
  input  sample_t                   sample,
  output logic                      result_valid,
  input  logic                      result_stall,
  output result_t                   result,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [FRAC_BITS-1:0]      cfg_data
);

  localparam int W = AXIS_BITS;
  localparam int F = FRAC_BITS;

  logic [F-1:0]     stick_dz;
  logic [F-1:0]     trigger_dz;
  logic [2*F-1:0]   stick_dz_sq;
  logic [2*F-1:0]   dz_prod;
  logic [W-1:0]     stick_den;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stick_dz   <= F'(STICK_DZ_RESET);
      trigger_dz <= F'(TRIGGER_DZ_RESET);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_STICK_DZ:   stick_dz   <= cfg_data;
        REG_TRIGGER_DZ: trigger_dz <= cfg_data;
        default: ;
      endcase
    end
  end

  // The squared deadzone settles the cycle after a write, well ahead of any sample using it.
  assign dz_prod = stick_dz * stick_dz;

  always_ff @(posedge clk) begin
    stick_dz_sq <= dz_prod;
  end

  assign stick_den = {1'b1, {F{1'b0}}} - {1'b0, stick_dz};

  logic en;

  assign sample_stall = result_valid && result_stall;
  assign en           = !sample_stall;

  // Trigger remap: adding one to a Q1.F value just flips its sign bit.
  logic [F:0]   lt_sh, rt_sh;
  logic         lt_act, rt_act;
  logic [F-1:0] lt_out, rt_out;

  always_comb begin
    lt_sh  = {~sample.raw_left_trigger[F], sample.raw_left_trigger[F-1:0]};
    rt_sh  = {~sample.raw_right_trigger[F], sample.raw_right_trigger[F-1:0]};
    lt_act = lt_sh >= {trigger_dz, 1'b0};
    rt_act = rt_sh >= {trigger_dz, 1'b0};
    lt_out = lt_act ? lt_sh[F:1] : '0;
    rt_out = rt_act ? rt_sh[F:1] : '0;
  end

  logic         l_valid, r_valid;
  logic [F:0]   l_side, r_side;

  gac_stick #(
    .AXIS_BITS(W),
    .SIDE_BITS(F + 1)
  ) u_left (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (sample_valid),
    .x        (sample.raw_left_x),
    .y        (sample.raw_left_y),
    .side_in  ({lt_act, lt_out}),
    .dz       (stick_dz),
    .dz_sq    (stick_dz_sq),
    .den      (stick_den),
    .out_valid(l_valid),
    .out_x    (result.out_left_x),
    .out_y    (result.out_left_y),
    .active   (result.left_stick_active),
    .side_out (l_side)
  );

  gac_stick #(
    .AXIS_BITS(W),
    .SIDE_BITS(F + 1)
  ) u_right (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (sample_valid),
    .x        (sample.raw_right_x),
    .y        (sample.raw_right_y),
    .side_in  ({rt_act, rt_out}),
    .dz       (stick_dz),
    .dz_sq    (stick_dz_sq),
    .den      (stick_den),
    .out_valid(r_valid),
    .out_x    (result.out_right_x),
    .out_y    (result.out_right_y),
    .active   (result.right_stick_active),
    .side_out (r_side)
  );

  assign result_valid                = l_valid && r_valid;
  assign result.out_left_trigger     = l_side[F-1:0];
  assign result.left_trigger_active  = l_side[F];
  assign result.out_right_trigger    = r_side[F-1:0];
  assign result.right_trigger_active = r_side[F];

endmodule

>>> tb/gamepad_axis_conditioner_test.sv
// Self-checking testbench for the gamepad axis conditioner with an exact fixed-point predictor.
module gamepad_axis_conditioner_test;
  import gac_pkg::*;

  localparam int ONE = 1 << FRAC_BITS;
  localparam int LATENCY = 3 * FRAC_BITS + 9;
  localparam int DRAIN_CYCLES = LATENCY + 10;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [CFG_INDEX_BITS-1:0] UNUSED_INDEX = 2'd3;

  logic clk;
  logic rst;
  logic sample_valid;
  logic sample_stall;
  sample_t sample;
  logic result_valid;
  logic result_stall;
  result_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [FRAC_BITS-1:0] cfg_data;

  // Predictor copy of the configuration registers.
  int unsigned stick_dz;
  int unsigned trigger_dz;

  sample_t pending_samples[$];
  result_t expected_results[$];
  int unsigned issued;
  int unsigned accepted;
  int unsigned idle_left;
  int unsigned stall_left;
  bit calm;
  int unsigned errors;
  int unsigned cycles;

  gamepad_axis_conditioner u_dut (
    .clk(clk),
    .rst(rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample(sample),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 20; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  function automatic logic signed [AXIS_BITS-1:0] scale_axis(longint a, longint unsigned r,
                                                            longint unsigned len);
    longint unsigned mag;
    longint q;
    mag = (a < 0) ? -a : a;
    q = (mag * r + (len >> 1)) / len;
    if (a < 0) begin
      q = -q;
      if (q < -ONE) q = -ONE;
    end else if (q > ONE - 1) begin
      q = ONE - 1;
    end
    return q[AXIS_BITS-1:0];
  endfunction

  function automatic void condition_stick(input logic signed [AXIS_BITS-1:0] x_in,
                                          input logic signed [AXIS_BITS-1:0] y_in,
                                          output logic signed [AXIS_BITS-1:0] x_out,
                                          output logic signed [AXIS_BITS-1:0] y_out,
                                          output logic active);
    longint x;
    longint y;
    longint unsigned sq;
    longint unsigned len;
    longint unsigned r;
    x = x_in;
    y = y_in;
    sq = x * x + y * y;
    x_out = '0;
    y_out = '0;
    active = (sq >= longint'(stick_dz) * stick_dz);
    if (active) begin
      len = floor_sqrt(sq);
      if (len != 0) begin
        r = ((len - stick_dz) << FRAC_BITS) / (ONE - stick_dz);
        if (r > ONE) r = ONE;
        x_out = scale_axis(x, r, len);
        y_out = scale_axis(y, r, len);
      end
    end
  endfunction

  function automatic void condition_trigger(input logic signed [AXIS_BITS-1:0] v,
                                            output logic [FRAC_BITS-1:0] level,
                                            output logic active);
    longint shifted;
    shifted = longint'(v) + ONE;
    active = (shifted >= 2 * longint'(trigger_dz));
    level = active ? shifted[FRAC_BITS:1] : '0;
  endfunction

  function automatic result_t condition_sample(sample_t s);
    result_t r;
    condition_stick(s.raw_left_x, s.raw_left_y, r.out_left_x, r.out_left_y,
                    r.left_stick_active);
    condition_stick(s.raw_right_x, s.raw_right_y, r.out_right_x, r.out_right_y,
                    r.right_stick_active);
    condition_trigger(s.raw_left_trigger, r.out_left_trigger, r.left_trigger_active);
    condition_trigger(s.raw_right_trigger, r.out_right_trigger, r.right_trigger_active);
    return r;
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Axis value biased toward the deadzone edge, the rails and zero.
  function automatic logic signed [AXIS_BITS-1:0] pick_axis();
    int unsigned mode;
    int span;
    mode = $urandom_range(0, 9);
    span = stick_dz + 64;
    if (mode < 4) return AXIS_BITS'($urandom);
    if (mode < 8) return AXIS_BITS'($urandom_range(0, 2 * span) - span);
    if (mode == 8) return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    return '0;
  endfunction

  function automatic logic signed [AXIS_BITS-1:0] pick_trigger();
    if ($urandom_range(0, 2) == 0)
      return AXIS_BITS'(2 * longint'(trigger_dz) - ONE + $urandom_range(0, 6) - 3);
    return AXIS_BITS'($urandom);
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    s.raw_left_x = pick_axis();
    s.raw_left_y = pick_axis();
    s.raw_right_x = pick_axis();
    s.raw_right_y = pick_axis();
    s.raw_left_trigger = pick_trigger();
    s.raw_right_trigger = pick_trigger();
    return s;
  endfunction

  function automatic sample_t make_sample(int lx, int ly, int rx, int ry, int lt, int rt);
    sample_t s;
    s.raw_left_x = AXIS_BITS'(lx);
    s.raw_left_y = AXIS_BITS'(ly);
    s.raw_right_x = AXIS_BITS'(rx);
    s.raw_right_y = AXIS_BITS'(ry);
    s.raw_left_trigger = AXIS_BITS'(lt);
    s.raw_right_trigger = AXIS_BITS'(rt);
    return s;
  endfunction

  task automatic wait_idle();
    while (!(pending_samples.size() == 0 && issued == accepted && expected_results.size() == 0))
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(logic [CFG_INDEX_BITS-1:0] index, int unsigned value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value[FRAC_BITS-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (index == REG_STICK_DZ) stick_dz = 32'(value[FRAC_BITS-1:0]);
    else if (index == REG_TRIGGER_DZ) trigger_dz = 32'(value[FRAC_BITS-1:0]);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(int unsigned count);
    repeat (count) pending_samples.push_back(random_sample());
    wait_idle();
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    sample_valid = 1'b0;
    sample = '0;
    result_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_STICK_DZ;
    cfg_data = '0;
    stick_dz = STICK_DZ_RESET;
    trigger_dz = TRIGGER_DZ_RESET;
    issued = 0;
    accepted = 0;
    idle_left = 0;
    stall_left = 0;
    calm = 1'b0;
    errors = 0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Directed samples at reset settings: rails, zero, deadzone edge, trigger rest and top.
    pending_samples.push_back(make_sample(0, 0, 0, 0, -32768, 32767));
    pending_samples.push_back(make_sample(32767, 32767, -32768, -32768, 32767, -32768));
    pending_samples.push_back(make_sample(32767, 0, 0, -32768, 0, -1));
    pending_samples.push_back(make_sample(4915, 0, 0, 4914, 3277 * 2 - ONE,
                                          3277 * 2 - ONE - 1));
    pending_samples.push_back(make_sample(3476, 3476, -3475, 3475, 1, -32767));
    pending_samples.push_back(make_sample(-32768, 32767, 20000, -25000, -100, 100));
    wait_idle();

    // Zero deadzones: a centered stick is active with zero outputs.
    write_register(REG_STICK_DZ, 0);
    write_register(REG_TRIGGER_DZ, 0);
    pending_samples.push_back(make_sample(0, 0, 1, -1, -32768, -32767));
    pending_samples.push_back(make_sample(32767, 0, -32768, 0, 32767, 0));
    pending_samples.push_back(make_sample(-32768, -32768, 1, 1, -1, 1));
    wait_idle();
    run_random(300);

    // Deadzones at full scale; the rescale denominator is one.
    write_register(REG_STICK_DZ, ONE - 1);
    write_register(REG_TRIGGER_DZ, ONE - 1);
    pending_samples.push_back(make_sample(32767, 0, 32767, 1, 32767, 32766));
    pending_samples.push_back(make_sample(-32768, 0, 23170, 23170, 32765, -32768));
    pending_samples.push_back(make_sample(32767, 32767, -32768, -32768, 0, 32767));
    wait_idle();
    run_random(300);

    // A write to an unused index must leave both registers alone.
    write_register(UNUSED_INDEX, 12345);
    write_register(REG_STICK_DZ, $urandom_range(1, ONE - 2));
    write_register(REG_TRIGGER_DZ, $urandom_range(1, ONE - 2));
    run_random(350);

    write_register(REG_STICK_DZ, $urandom_range(16000, ONE - 2));
    write_register(REG_TRIGGER_DZ, $urandom_range(0, 2000));
    run_random(350);

    // Last stretch at reset values, with no idling on either side.
    write_register(REG_STICK_DZ, STICK_DZ_RESET);
    write_register(REG_TRIGGER_DZ, TRIGGER_DZ_RESET);
    calm = 1'b1;
    run_random(450);

    if (errors == 0) begin
      $display("gamepad_axis_conditioner_test: clean");
    end else begin
      $display("gamepad_axis_conditioner_test: errors");
    end
    $finish;
  end

  // Sample driver; a new item goes out only once the previous transfer is done.
  always @(negedge clk) begin
    if (!rst && issued == accepted) begin
      if (idle_left > 0) begin
        idle_left--;
        sample_valid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        sample <= pending_samples.pop_front();
        sample_valid <= 1'b1;
        issued++;
        if (!calm && $urandom_range(0, 3) == 0) idle_left = $urandom_range(1, 9);
      end else begin
        sample_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
      if (!calm && !rst && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 9);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (sample_valid && !sample_stall) begin
        expected_results.push_back(condition_sample(sample));
        accepted++;
      end
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no sample outstanding");
          errors++;
        end else begin
          result_t want;
          want = expected_results.pop_front();
          check_field("out_left_x", want.out_left_x, result.out_left_x);
          check_field("out_left_y", want.out_left_y, result.out_left_y);
          check_field("out_right_x", want.out_right_x, result.out_right_x);
          check_field("out_right_y", want.out_right_y, result.out_right_y);
          check_field("out_left_trigger", want.out_left_trigger, result.out_left_trigger);
          check_field("out_right_trigger", want.out_right_trigger, result.out_right_trigger);
          check_field("left_stick_active", want.left_stick_active, result.left_stick_active);
          check_field("right_stick_active", want.right_stick_active,
                      result.right_stick_active);
          check_field("left_trigger_active", want.left_trigger_active,
                      result.left_trigger_active);
          check_field("right_trigger_active", want.right_trigger_active,
                      result.right_trigger_active);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("gamepad_axis_conditioner_test: errors");
      $finish;
    end
  end

endmodule
